[hw/rtl/ctc_pkg.sv]
// Shared types and constants for the C token classifier.
// Holds beat formats, result kinds, queue sizing and the keyword/operator tables.
// No dependencies.
package ctc_pkg;

  localparam int MAX_TOKEN_LEN = 4095;
  localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
  localparam int NUM_KW        = 16;
  localparam int NUM_OP        = 11;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    KIND_KEYWORD  = 3'd0,
    KIND_INTEGER  = 3'd1,
    KIND_FLOAT    = 3'd2,
    KIND_OPERATOR = 3'd3,
    KIND_IDENT    = 3'd4,
    KIND_LINE_END = 3'd5,
    KIND_ERROR    = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    kind_t kind;
    logic  last;
  } out_item_t;

  // one queue entry: a line end, or a token result with an optional line end
  typedef struct packed {
    logic  two;
    kind_t kind0;
  } ev_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    "const", "int", "float", "double", "long", "static", "void", "char",
    "extern", "return", "break", "enum", "struct", "typedef", "union", "goto"
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd5, 4'd3, 4'd5, 4'd6, 4'd4, 4'd6, 4'd4, 4'd4,
    4'd6, 4'd6, 4'd5, 4'd4, 4'd6, 4'd7, 4'd5, 4'd4
  };

  localparam logic [15:0] OP_TEXT [NUM_OP] = '{
    "+", "-", "*", "/", "=", "==", "!=", ">=", "<=", ">", "<"
  };
  localparam logic [1:0] OP_LEN [NUM_OP] = '{
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1
  };

endpackage

[hw/rtl/ctc_front.sv]
// Front end: accepts character beats, tracks the open token and classifies it.
// Pushes one queue entry per beat that yields results.
// Depends on ctc_pkg.
module ctc_front import ctc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     push,
  output ev_t      push_ev
);

  typedef struct packed {
    logic              in_tok;
    logic [NUM_KW-1:0] kw_hits;
    logic [NUM_OP-1:0] op_hits;
    logic [LEN_W-1:0]  len;
    logic [7:0]        first;
    logic [7:0]        second;
    logic [1:0]        dots;
    logic              all_num;
    logic              all_id;
  } tok_t;

  localparam tok_t TOK_CLEAR = '{
    in_tok: 1'b0, kw_hits: '1, op_hits: '1, len: '0, first: 8'd0,
    second: 8'd0, dots: 2'd0, all_num: 1'b1, all_id: 1'b1
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha_us(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic [7:0] kw_char(input logic [63:0] txt, input logic [3:0] len,
                                         input logic [2:0] pos);
    logic [63:0] al;
    logic [2:0]  pad;
    pad = 3'(4'd8 - len);
    al  = txt << {pad, 3'b000};
    return al[{3'd7 - pos, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] op_char(input logic [15:0] txt, input logic [1:0] len,
                                         input logic pos);
    logic [15:0] al;
    al = (len == 2'd1) ? {txt[7:0], 8'd0} : txt;
    return pos ? al[7:0] : al[15:8];
  endfunction

  function automatic kind_t classify(input tok_t t);
    kind_t k;
    k = KIND_ERROR;
    if (is_digit(t.first) || (t.first == ".")) begin
      if (!t.all_num) begin
        k = KIND_ERROR;
      end else if (t.dots == 2'd0) begin
        k = ((t.len != LEN_W'(1)) && (t.first == "0")) ? KIND_ERROR : KIND_INTEGER;
      end else if (t.dots == 2'd1) begin
        k = ((t.first == "0") && (t.second != ".")) ? KIND_ERROR : KIND_FLOAT;
      end else begin
        k = KIND_ERROR;
      end
    end else if (is_alpha_us(t.first)) begin
      k = t.all_id ? KIND_IDENT : KIND_ERROR;
    end
    for (int i = NUM_OP - 1; i >= 0; i--) begin
      if (t.op_hits[i] && (t.len == LEN_W'(OP_LEN[i]))) begin
        k = KIND_OPERATOR;
      end
    end
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      if (t.kw_hits[i] && (t.len == LEN_W'(KW_LEN[i]))) begin
        k = KIND_KEYWORD;
      end
    end
    return k;
  endfunction

  tok_t   tok_r, tok_nxt, tok_a, tok_c;
  logic   failed_r, failed_nxt;
  logic   acc, is_semi, is_sp, is_abs, do_close;
  kind_t  k;
  logic [7:0] c;

  assign c        = in_data.ch;
  assign in_stall = q_stat.full;
  assign acc      = in_valid && !q_stat.full;
  assign is_semi  = (c == ";");
  assign is_sp    = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  assign is_abs   = !is_semi && !is_sp;

  always_comb begin
    tok_a = tok_r;
    for (int i = 0; i < NUM_KW; i++) begin
      if ((tok_r.len >= LEN_W'(KW_LEN[i])) ||
          (kw_char(KW_TEXT[i], KW_LEN[i], tok_r.len[2:0]) != c)) begin
        tok_a.kw_hits[i] = 1'b0;
      end
    end
    for (int i = 0; i < NUM_OP; i++) begin
      if ((tok_r.len >= LEN_W'(OP_LEN[i])) ||
          (op_char(OP_TEXT[i], OP_LEN[i], tok_r.len[0]) != c)) begin
        tok_a.op_hits[i] = 1'b0;
      end
    end
    if (tok_r.len == '0) begin
      tok_a.first = c;
    end
    if (tok_r.len == LEN_W'(1)) begin
      tok_a.second = c;
    end
    if ((c == ".") && (tok_r.dots != 2'd2)) begin
      tok_a.dots = tok_r.dots + 2'd1;
    end
    if (!(is_digit(c) || (c == "."))) begin
      tok_a.all_num = 1'b0;
    end
    if (!(is_alpha_us(c) || is_digit(c))) begin
      tok_a.all_id = 1'b0;
    end
    if (tok_r.len != LEN_W'(MAX_TOKEN_LEN)) begin
      tok_a.len = tok_r.len + LEN_W'(1);
    end
    tok_a.in_tok = 1'b1;
  end

  always_comb begin
    tok_c    = is_abs ? tok_a : tok_r;
    k        = classify(tok_c);
    do_close = tok_c.in_tok && (is_semi || is_sp || in_data.end_of_text);
    if (do_close || in_data.end_of_text) begin
      tok_nxt = TOK_CLEAR;
    end else begin
      tok_nxt = tok_c;
    end
    failed_nxt    = do_close && (k == KIND_ERROR);
    push          = acc && !failed_r && (do_close || is_semi);
    push_ev.kind0 = do_close ? k : KIND_LINE_END;
    push_ev.two   = do_close && is_semi && (k != KIND_ERROR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= TOK_CLEAR;
      failed_r <= 1'b0;
    end else if (acc && !failed_r) begin
      tok_r    <= tok_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

[hw/rtl/ctc_queue.sv]
// Short queue of result entries between the front and back ends.
// Depends on ctc_pkg.
module ctc_queue import ctc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  ev_t     push_ev,
  input  logic    pop,
  output ev_t     head,
  output q_stat_t q_stat
);

  ev_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

[hw/rtl/ctc_back.sv]
// Back end: expands queue entries into result beats through an output register.
// Depends on ctc_pkg.
module ctc_back import ctc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ev_t       head,
  input  q_stat_t   q_stat,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      half_r, half_nxt;
  logic      load;

  assign load      = (!out_valid_r || !out_stall) && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    pop           = 1'b0;
    half_nxt      = half_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (half_r) begin
        out_data_nxt = '{kind: KIND_LINE_END, last: 1'b1};
        half_nxt     = 1'b0;
        pop          = 1'b1;
      end else if (head.two) begin
        out_data_nxt = '{kind: head.kind0, last: 1'b0};
        half_nxt     = 1'b1;
      end else begin
        out_data_nxt = '{kind: head.kind0, last: 1'b1};
        pop          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      half_r      <= half_nxt;
    end
  end

endmodule

[hw/rtl/c_token_classifier_core.sv]
// Top level of the C token classifier: front end, result queue, back end.
// Depends on ctc_pkg, ctc_front, ctc_queue, ctc_back.
//
//  channel | dir | handshake            | beat
//  in_     | in  | in_valid / in_stall  | in_item_t  {ch, end_of_text}
//  out_    | out | out_valid / out_stall| out_item_t {kind, last}
//
// One character beat is taken per cycle unless stalled; it is classified in that cycle.
// Registered results leave one per cycle if unstalled; ';' closing a valid token gives two.
// A four-entry queue parts the two sides, so in_stall rises only when that queue is full.
// Reset (rst_n low, synchronous) clears the token state, the error latch and the queue.
module c_token_classifier_core import ctc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic    push, pop;
  ev_t     push_ev, head;
  q_stat_t q_stat;

  ctc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_ev  (push_ev)
  );

  ctc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ev (push_ev),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  ctc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/ctc_checker.sv]
// Port-level checks for the C token classifier, bound to the top level.
// Depends on ctc_pkg and c_token_classifier_core.
module ctc_checker import ctc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kind != KIND_LINE_END) || out_data.last)
    else $error("line end not marked last");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_ERROR) |-> out_data.last)
    else $error("error result not marked last");

  a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_data.kind == KIND_ERROR) |=> !out_valid)
    else $error("result after error");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind c_token_classifier_core ctc_checker u_ctc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[bench/tb_c_token_classifier_core.sv]
// Self-checking bench for c_token_classifier_core: feeds C-like source text byte by byte
// and checks every token kind against an in-bench classifier. Depends on ctc_pkg and the core.
// Drives at the falling edge, samples at the rising edge.
`timescale 1ns / 1ps

module tb_c_token_classifier_core;
  import ctc_pkg::*;

  localparam int TOKEN_LEN_CAP = MAX_TOKEN_LEN;
  localparam int RUN_LIMIT     = 500000;
  localparam int BODY_BEATS    = 1000;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_LOW_A = "a";
  localparam logic [7:0] CH_LOW_B = "b";
  localparam logic [7:0] CH_LOW_C = "c";
  localparam logic [7:0] CH_LOW_Z = "z";
  localparam logic [7:0] CH_UP_A  = "A";
  localparam logic [7:0] CH_UP_Z  = "Z";
  localparam logic [7:0] CH_US    = "_";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_GT    = ">";

  typedef struct packed {
    in_item_t beat;
    logic     drain;
  } stim_t;

  typedef enum logic [1:0] {FLOW, SPARSE, TOGGLE, HEAVY} stall_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  c_token_classifier_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stim_t       pending [$];
  logic [7:0]  word_buf [$];
  out_item_t   kinds_due [$];
  logic        in_fire = 1'b0;
  int          beats_in = 0;
  int          results_seen = 0;
  int          errors = 0;
  int          cycles = 0;

  // classifier state
  logic        tok_open;
  logic [15:0] kw_alive;
  logic [10:0] op_alive;
  logic [LEN_W-1:0] tok_len;
  logic [7:0]  c0;
  logic [7:0]  c1;
  logic [1:0]  dots;
  logic        numeric_ok;
  logic        ident_ok;
  logic        jammed;
  kind_t       step_kind [2];
  int          step_n;

  function automatic logic [63:0] kw_word(input int i);
    case (i)
      0:  kw_word = "const";
      1:  kw_word = "int";
      2:  kw_word = "float";
      3:  kw_word = "double";
      4:  kw_word = "long";
      5:  kw_word = "static";
      6:  kw_word = "void";
      7:  kw_word = "char";
      8:  kw_word = "extern";
      9:  kw_word = "return";
      10: kw_word = "break";
      11: kw_word = "enum";
      12: kw_word = "struct";
      13: kw_word = "typedef";
      14: kw_word = "union";
      default: kw_word = "goto";
    endcase
  endfunction

  function automatic logic [63:0] op_word(input int i);
    case (i)
      0:  op_word = "+";
      1:  op_word = "-";
      2:  op_word = "*";
      3:  op_word = "/";
      4:  op_word = "=";
      5:  op_word = "==";
      6:  op_word = "!=";
      7:  op_word = ">=";
      8:  op_word = "<=";
      9:  op_word = ">";
      default: op_word = "<";
    endcase
  endfunction

  function automatic int word_len(input logic [63:0] w);
    int n;
    n = 0;
    for (int k = 0; k < 8; k++)
      if (w[k*8 +: 8] != 8'h00) n++;
    return n;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) || c == CH_US;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic clear_tok();
    tok_open   = 1'b0;
    kw_alive   = '1;
    op_alive   = '1;
    tok_len    = '0;
    c0         = '0;
    c1         = '0;
    dots       = '0;
    numeric_ok = 1'b1;
    ident_ok   = 1'b1;
  endtask

  task automatic take_char(input logic [7:0] c);
    int p;
    int n;
    logic [63:0] w;
    p = tok_len;
    for (int i = 0; i < 16; i++) begin
      w = kw_word(i);
      n = word_len(w);
      if (p >= n) kw_alive[i] = 1'b0;
      else if (w[(n-1-p)*8 +: 8] != c) kw_alive[i] = 1'b0;
    end
    for (int i = 0; i < 11; i++) begin
      w = op_word(i);
      n = word_len(w);
      if (p >= n) op_alive[i] = 1'b0;
      else if (w[(n-1-p)*8 +: 8] != c) op_alive[i] = 1'b0;
    end
    if (p == 0) c0 = c;
    if (p == 1) c1 = c;
    if (c == CH_DOT && dots < 2) dots = dots + 1'b1;
    if (!(is_digit(c) || c == CH_DOT)) numeric_ok = 1'b0;
    if (!(is_alpha(c) || is_digit(c))) ident_ok = 1'b0;
    if (tok_len < TOKEN_LEN_CAP) tok_len = tok_len + 1'b1;
    tok_open = 1'b1;
  endtask

  function automatic kind_t token_kind();
    for (int i = 0; i < 16; i++)
      if (kw_alive[i] && tok_len == word_len(kw_word(i))) return KIND_KEYWORD;
    for (int i = 0; i < 11; i++)
      if (op_alive[i] && tok_len == word_len(op_word(i))) return KIND_OPERATOR;
    if (c0 == CH_DOT || is_digit(c0)) begin
      if (!numeric_ok) return KIND_ERROR;
      if (dots == 0) begin
        if (tok_len != 1 && c0 == CH_ZERO) return KIND_ERROR;
        return KIND_INTEGER;
      end
      if (dots == 1) begin
        if (c0 == CH_ZERO && c1 != CH_DOT) return KIND_ERROR;
        return KIND_FLOAT;
      end
      return KIND_ERROR;
    end
    if (is_alpha(c0)) begin
      if (ident_ok) return KIND_IDENT;
      return KIND_ERROR;
    end
    return KIND_ERROR;
  endfunction

  task automatic close_tok();
    kind_t k;
    if (!tok_open) return;
    k = token_kind();
    clear_tok();
    step_kind[step_n] = k;
    step_n++;
    if (k == KIND_ERROR) jammed = 1'b1;
  endtask

  task automatic classify_beat(input in_item_t b);
    out_item_t r;
    if (jammed) return;
    step_n = 0;
    if (b.ch == CH_SEMI) begin
      close_tok();
      if (!jammed) begin
        step_kind[step_n] = KIND_LINE_END;
        step_n++;
      end
    end else if (is_blank(b.ch)) begin
      close_tok();
    end else begin
      take_char(b.ch);
    end
    if (b.end_of_text && !jammed) close_tok();
    if (b.end_of_text) clear_tok();
    for (int i = 0; i < step_n; i++) begin
      r.kind = step_kind[i];
      r.last = (i == step_n - 1);
      kinds_due.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
  endtask

  // ---------------- stimulus ----------------
  task automatic push_byte(input logic [7:0] c, input logic eot, input logic drain);
    stim_t s;
    s.beat.ch          = c;
    s.beat.end_of_text = eot;
    s.drain            = drain;
    pending.push_back(s);
  endtask

  task automatic flush_word(input logic eot, input logic drain);
    for (int i = 0; i < word_buf.size(); i++)
      push_byte(word_buf[i], eot && (i == word_buf.size() - 1), drain && (i == 0));
    word_buf.delete();
  endtask

  task automatic say(input string s, input logic eot);
    for (int i = 0; i < s.len(); i++) word_buf.push_back(s[i]);
    flush_word(eot, 1'b0);
  endtask

  function automatic logic [7:0] rand_digit(input int lo);
    return CH_ZERO + 8'($urandom_range(lo, 9));
  endfunction

  function automatic logic [7:0] rand_alpha();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return CH_LOW_A + 8'(r);
    if (r < 52) return CH_UP_A + 8'(r - 26);
    return CH_US;
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 62) < 53) return rand_alpha();
    return rand_digit(0);
  endfunction

  function automatic logic [7:0] rand_blank();
    int k;
    k = $urandom_range(0, 5);
    if (k == 0) return CH_SPACE;
    return CH_TAB + 8'(k - 1);
  endfunction

  task automatic put_word(input logic [63:0] w, input int n);
    for (int p = 0; p < n; p++) word_buf.push_back(w[(n-1-p)*8 +: 8]);
  endtask

  task automatic gen_token();
    logic [63:0] w;
    int n;
    case ($urandom_range(0, 4))
      0: begin
        w = kw_word($urandom_range(0, 15));
        put_word(w, word_len(w));
      end
      1: begin
        w = op_word($urandom_range(0, 10));
        put_word(w, word_len(w));
      end
      2: begin
        if ($urandom_range(0, 4) == 0) begin
          word_buf.push_back(CH_ZERO);
        end else begin
          word_buf.push_back(rand_digit(1));
          repeat ($urandom_range(0, 6)) word_buf.push_back(rand_digit(0));
        end
      end
      3: begin
        case ($urandom_range(0, 2))
          0: begin
            word_buf.push_back(CH_ZERO);
            word_buf.push_back(CH_DOT);
          end
          1: word_buf.push_back(CH_DOT);
          default: begin
            word_buf.push_back(rand_digit(1));
            repeat ($urandom_range(0, 3)) word_buf.push_back(rand_digit(0));
            word_buf.push_back(CH_DOT);
          end
        endcase
        repeat ($urandom_range(0, 4)) word_buf.push_back(rand_digit(0));
      end
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          w = kw_word($urandom_range(0, 15));
          n = word_len(w);
          if ($urandom_range(0, 1) == 0) begin
            put_word(w, n);
            word_buf.push_back(rand_alnum());
          end else begin
            for (int p = 0; p < n - 1; p++) word_buf.push_back(w[(n-1-p)*8 +: 8]);
          end
        end else begin
          word_buf.push_back(rand_alpha());
          repeat ($urandom_range(0, 7)) word_buf.push_back(rand_alnum());
        end
      end
    endcase
  endtask

  task automatic gen_separator();
    int n;
    if ($urandom_range(0, 9) < 6) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        push_byte(rand_blank(), i == n - 1 && $urandom_range(0, 29) == 0, 1'b0);
    end else begin
      push_byte(CH_SEMI, $urandom_range(0, 29) == 0, 1'b0);
      if ($urandom_range(0, 1) == 0) push_byte(rand_blank(), 1'b0, 1'b0);
    end
  endtask

  task automatic gen_bad_token();
    case ($urandom_range(0, 7))
      0: begin
        word_buf.push_back(CH_DOT);
        word_buf.push_back(CH_DOT);
      end
      1: begin
        word_buf.push_back(rand_digit(1));
        word_buf.push_back(CH_DOT);
        word_buf.push_back(rand_digit(0));
        word_buf.push_back(CH_DOT);
        word_buf.push_back(rand_digit(0));
      end
      2: begin
        word_buf.push_back(CH_ZERO);
        word_buf.push_back(rand_digit(0));
        word_buf.push_back(CH_DOT);
        word_buf.push_back(rand_digit(0));
      end
      3: begin
        word_buf.push_back(CH_ZERO);
        repeat ($urandom_range(1, 3)) word_buf.push_back(rand_digit(0));
      end
      4: begin
        word_buf.push_back(CH_LOW_A);
        word_buf.push_back(CH_LOW_B);
        word_buf.push_back(8'($urandom_range(128, 255)));
        word_buf.push_back(CH_LOW_C);
      end
      5: begin
        word_buf.push_back(($urandom_range(0, 1) == 0) ? CH_NUL : CH_HASH);
        word_buf.push_back(rand_alpha());
      end
      6: begin
        word_buf.push_back(CH_EQ);
        word_buf.push_back(CH_GT);
      end
      default: begin
        word_buf.push_back(rand_digit(0));
        word_buf.push_back(CH_LOW_A + 8'($urandom_range(0, 25)));
      end
    endcase
  endtask

  initial begin
    clear_tok();
    jammed = 1'b0;
    step_n = 0;

    say("int", 1'b0);
    push_byte(CH_TAB, 1'b0, 1'b0);
    say("_Z9", 1'b0);
    push_byte(CH_SPACE, 1'b0, 1'b0);
    say("0", 1'b0);
    push_byte(CH_CR, 1'b0, 1'b0);
    say("0.5;==", 1'b0);
    push_byte(CH_LF, 1'b0, 1'b0);
    say(";", 1'b0);
    push_byte(CH_VT, 1'b0, 1'b0);
    push_byte(CH_FF, 1'b0, 1'b0);
    say("7.", 1'b1);
    push_byte(CH_SPACE, 1'b1, 1'b0);

    while (pending.size() < BODY_BEATS) begin
      gen_token();
      flush_word($urandom_range(0, 24) == 0, $urandom_range(0, 149) == 0);
      gen_separator();
    end

    // one fatal token, then bytes that must stay silent
    gen_bad_token();
    flush_word(1'b0, 1'b1);
    push_byte(CH_SEMI, 1'b0, 1'b0);
    push_byte(CH_NUL, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    repeat (30) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (kinds_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------- sender ----------------
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) pending.delete(0);
      if (in_valid && !in_fire) begin
        // hold the stalled beat
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending[0].drain && kinds_due.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending[0].beat;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // ---------------- receiver ----------------
  int          hold_left = 0;
  int          next_hold_at = 300;
  int          mode_left = 0;
  stall_mode_t stall_mode = FLOW;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && beats_in >= next_hold_at) begin
        hold_left    = 90;
        next_hold_at = next_hold_at + 700;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left  = $urandom_range(16, 96);
        end
        mode_left--;
        case (stall_mode)
          FLOW:    out_stall <= 1'b0;
          SPARSE:  out_stall <= ($urandom_range(0, 2) == 0);
          TOGGLE:  out_stall <= ~out_stall;
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (kinds_due.size() == 0) begin
          report_mismatch("result with none pending, kind", out_data.kind, -1);
        end else begin
          want = kinds_due.pop_front();
          if (out_data.kind !== want.kind) report_mismatch("kind", out_data.kind, want.kind);
          if (out_data.last !== want.last) report_mismatch("last", out_data.last, want.last);
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        classify_beat(in_data);
        beats_in++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
